[rtl/core/thermal_frame_mean_tracker_core_defines.svh]
// ----------------------------------------------------------------------------
// Thermal frame mean tracker: assertion macros
// Concurrent assertion wrappers for the core's RTL files (used by tfmt_ctrl).
// ----------------------------------------------------------------------------
`ifndef THERMAL_FRAME_MEAN_TRACKER_CORE_DEFINES_SVH
`define THERMAL_FRAME_MEAN_TRACKER_CORE_DEFINES_SVH

// Assertion on the local clock with an explicit disable condition
`define TFMT_ASSERT_DIS(label, rst, prop, msg) \
   label: assert property (@(posedge clock) disable iff (rst) prop) else $error(msg);

// Assertion on the local clock, disabled while the local reset is high
`define TFMT_ASSERT(label, prop, msg) `TFMT_ASSERT_DIS(label, reset, prop, msg)

`endif

[rtl/core/tfmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker package
// Field widths, register map, reset values, state and control types.
// ----------------------------------------------------------------------------
package tfmt_pkg;

   // Field widths
   localparam int PIXEL_W    = 16;
   localparam int COUNT_W    = 11;
   localparam int TIMER_W    = 16;
   localparam int WEIGHT_W   = 9;
   localparam int JUMP_W     = 15;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Fixed-point format of temperatures and the "no value" code
   localparam int TEMP_FRAC_BITS = 6;
   localparam logic signed [PIXEL_W-1:0] SENTINEL = -(16'sd1 <<< TEMP_FRAC_BITS);

   // Full smoothing weight (unity, over 256)
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
   localparam logic [TIMER_W-1:0]  TIMER_MAX  = 16'hFFFF;

   // Register indexes
   localparam logic [2:0] REG_WINDOW_LOW   = 3'd0;
   localparam logic [2:0] REG_WINDOW_HIGH  = 3'd1;
   localparam logic [2:0] REG_AREA_THRESH  = 3'd2;
   localparam logic [2:0] REG_DEBOUNCE     = 3'd3;
   localparam logic [2:0] REG_WEIGHT       = 3'd4;
   localparam logic [2:0] REG_JUMP_LIMIT   = 3'd5;

   // Register reset values
   localparam logic signed [PIXEL_W-1:0] RST_WINDOW_LOW  = 16'sd1984;
   localparam logic signed [PIXEL_W-1:0] RST_WINDOW_HIGH = 16'sd2496;
   localparam logic [COUNT_W-1:0]        RST_AREA_THRESH = 11'd20;
   localparam logic [TIMER_W-1:0]        RST_DEBOUNCE    = 16'd10;
   localparam logic [WEIGHT_W-1:0]       RST_WEIGHT      = 9'd230;
   localparam logic [JUMP_W-1:0]         RST_JUMP_LIMIT  = 15'd38;

   // Configuration seen by the datapath
   typedef struct packed {
      logic signed [PIXEL_W-1:0] window_low;
      logic signed [PIXEL_W-1:0] window_high;
      logic [COUNT_W-1:0]        area_threshold;
      logic [TIMER_W-1:0]        debounce_frames;
      logic [WEIGHT_W-1:0]       smoothing_weight;
      logic [JUMP_W-1:0]         jump_limit;
   } cfg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MEAN,
      ST_SMOOTH,
      ST_PUSH
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accum;
      logic load;
      logic mean;
      logic smooth;
      logic push;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic div_done;
   } stat_type;

endpackage

[rtl/core/tfmt_channel_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker channels
// Valid/ready channels for pixel words and frame result words.
// ----------------------------------------------------------------------------
interface tfmt_req_if;
   import tfmt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [PIXEL_W-1:0] pixel_temp;
   logic                      frame_end;

   modport source (output valid, output pixel_temp, output frame_end, input ready);
   modport sink   (input valid, input pixel_temp, input frame_end, output ready);
endinterface

interface tfmt_rsp_if;
   import tfmt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COUNT_W-1:0]        in_range_count;
   logic signed [PIXEL_W-1:0] frame_mean;
   logic signed [PIXEL_W-1:0] smoothed_mean;
   logic                      present_now;
   logic                      present_stable;

   modport source (output valid, output in_range_count, output frame_mean,
                   output smoothed_mean, output present_now, output present_stable,
                   input ready);
   modport sink   (input valid, input in_range_count, input frame_mean,
                   input smoothed_mean, input present_now, input present_stable,
                   output ready);
endinterface

[rtl/core/thermal_frame_mean_tracker_core.sv]
`timescale 1ns / 1ps
// Throughput: one pixel word per cycle within a frame; the frame_end word stalls intake.
// Result path: the frame_end word moves the controller to LOAD, then DIV (the
//   one-bit-per-cycle mean divider), MEAN, SMOOTH and PUSH; PUSH waits for a free output.
// A frame with no in-range pixel skips the divider, going from LOAD straight to MEAN.
// Reset is synchronous, active high: clears accumulators, flags, timer, smoothed value,
//   and loads register defaults.
// ----------------------------------------------------------------------------
// Thermal frame mean tracker core
// Per-frame windowed pixel count, mean, debounced presence and smoothed mean.
// ----------------------------------------------------------------------------
module thermal_frame_mean_tracker_core #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   tfmt_req_if.sink                        req,
   tfmt_rsp_if.source                      rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tfmt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tfmt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tfmt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import tfmt_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type st;
   logic     req_ready;
   logic     rsp_valid;

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

   tfmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tfmt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_frame_end (req.frame_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp.ready),
      .cmd           (cmd),
      .st            (st)
   );

   tfmt_dp #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .st             (st),
      .pixel_temp     (req.pixel_temp),
      .in_range_count (rsp.in_range_count),
      .frame_mean     (rsp.frame_mean),
      .smoothed_mean  (rsp.smoothed_mean),
      .present_now    (rsp.present_now),
      .present_stable (rsp.present_stable)
   );

endmodule

[rtl/core/tfmt_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker register file
// APB-style write/read port for the six configuration registers.
// ----------------------------------------------------------------------------
module tfmt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tfmt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tfmt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tfmt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output tfmt_pkg::cfg_type                   cfg
);
   import tfmt_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Decode writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_WINDOW_LOW:  cfg_in.window_low       = pwdata[PIXEL_W-1:0];
            REG_WINDOW_HIGH: cfg_in.window_high      = pwdata[PIXEL_W-1:0];
            REG_AREA_THRESH: cfg_in.area_threshold   = pwdata[COUNT_W-1:0];
            REG_DEBOUNCE:    cfg_in.debounce_frames  = pwdata[TIMER_W-1:0];
            REG_WEIGHT:      cfg_in.smoothing_weight = pwdata[WEIGHT_W-1:0];
            REG_JUMP_LIMIT:  cfg_in.jump_limit       = pwdata[JUMP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low       <= RST_WINDOW_LOW;
         cfg_ff.window_high      <= RST_WINDOW_HIGH;
         cfg_ff.area_threshold   <= RST_AREA_THRESH;
         cfg_ff.debounce_frames  <= RST_DEBOUNCE;
         cfg_ff.smoothing_weight <= RST_WEIGHT;
         cfg_ff.jump_limit       <= RST_JUMP_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_WINDOW_LOW:  prdata = {16'h0, cfg_ff.window_low};
         REG_WINDOW_HIGH: prdata = {16'h0, cfg_ff.window_high};
         REG_AREA_THRESH: prdata = {21'h0, cfg_ff.area_threshold};
         REG_DEBOUNCE:    prdata = {16'h0, cfg_ff.debounce_frames};
         REG_WEIGHT:      prdata = {23'h0, cfg_ff.smoothing_weight};
         REG_JUMP_LIMIT:  prdata = {17'h0, cfg_ff.jump_limit};
         default:         prdata = '0;
      endcase
   end

endmodule

[rtl/core/tfmt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfmt_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   assign done     = busy_ff && (cnt_ff == CNT_W'(NUM_W - 1));
   assign quotient = quo_ff;

   // Shift in one dividend bit, trial subtract, restore on borrow
   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

[rtl/core/tfmt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker datapath
// Window accumulation, presence debounce, mean and smoothed mean, result word.
// ----------------------------------------------------------------------------
module tfmt_dp #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tfmt_pkg::cfg_type                   cfg,
   input  tfmt_pkg::cmd_type                   cmd,
   output tfmt_pkg::stat_type                  st,
   input  logic signed [tfmt_pkg::PIXEL_W-1:0] pixel_temp,
   output logic [tfmt_pkg::COUNT_W-1:0]        in_range_count,
   output logic signed [tfmt_pkg::PIXEL_W-1:0] frame_mean,
   output logic signed [tfmt_pkg::PIXEL_W-1:0] smoothed_mean,
   output logic                                present_now,
   output logic                                present_stable
);
   import tfmt_pkg::*;

   localparam int CW   = $clog2(MAX_PIXELS + 1);
   localparam int SW   = CW + PIXEL_W;
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

   // Frame accumulators and tracking state
   logic signed [SW-1:0]      sum_ff, sum_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      present_ff, present_in;
   logic                      stable_ff, stable_in;
   logic [TIMER_W-1:0]        timer_ff, timer_in;
   logic signed [PIXEL_W-1:0] smooth_ff, smooth_in;

   // Captured frame values
   logic [CW-1:0]             cap_count_ff;
   logic                      sum_neg_ff;
   logic signed [PIXEL_W-1:0] mean_ff, mean_in;

   // Result word
   logic [COUNT_W-1:0]        out_count_ff;
   logic signed [PIXEL_W-1:0] out_mean_ff;
   logic signed [PIXEL_W-1:0] out_smooth_ff;
   logic                      out_present_ff;
   logic                      out_stable_ff;

   logic                      in_window;
   logic [SW-1:0]             sum_mag;
   logic [SW-1:0]             quotient;
   logic                      div_start;
   logic                      div_done;
   logic                      present_cur;
   logic [CMPW-1:0]           count_ext;
   logic [CMPW-1:0]           cap_ext;
   logic [PIXEL_W-1:0]        q_low;

   logic signed [PIXEL_W:0]   diff;
   logic [PIXEL_W:0]          abs_diff;
   logic [WEIGHT_W-1:0]       w_sat;
   logic signed [26:0]        prod;
   logic signed [27:0]        num;
   logic                      mean_valid;
   logic                      smooth_pos;

   assign count_ext = CMPW'(count_ff);
   assign cap_ext   = CMPW'(cap_count_ff);

   // Pixel strictly inside the window, below the pixel cap
   assign in_window = (pixel_temp > cfg.window_low) && (pixel_temp < cfg.window_high)
                      && (count_ff < CW'(MAX_PIXELS));

   assign sum_mag     = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign div_start   = cmd.load && (count_ff != '0);
   assign present_cur = count_ext > CMPW'(cfg.area_threshold);

   assign st.count_zero = (count_ff == '0);
   assign st.div_done   = div_done;

   tfmt_div #(
      .NUM_W (SW),
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (sum_mag),
      .denom    (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Accumulate, then clear at frame capture
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.load) begin
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.accum && in_window) begin
         sum_in   = sum_ff + SW'(pixel_temp);
         count_in = count_ff + CW'(1);
      end
   end

   // Presence flag and debounce timer
   always_comb begin
      present_in = present_ff;
      stable_in  = stable_ff;
      timer_in   = timer_ff;
      if (cmd.load) begin
         if (present_cur != present_ff) begin
            timer_in = '0;
         end else if (timer_ff != TIMER_MAX) begin
            timer_in = timer_ff + TIMER_W'(1);
         end
         if (timer_in > cfg.debounce_frames) begin
            stable_in = present_cur;
         end
         present_in = present_cur;
      end
   end

   // Signed mean from the magnitude quotient
   assign q_low = quotient[PIXEL_W-1:0];
   always_comb begin
      if (cap_count_ff == '0) begin
         mean_in = SENTINEL;
      end else if (sum_neg_ff) begin
         mean_in = -$signed(q_low);
      end else begin
         mean_in = $signed(q_low);
      end
   end

   // Smoothing: 256*mean + w*(old - mean), rounded, floor divided by 256; a jump at or over the limit takes the mean
   always_comb begin
      diff       = {smooth_ff[PIXEL_W-1], smooth_ff} - {mean_ff[PIXEL_W-1], mean_ff};
      abs_diff   = diff[PIXEL_W] ? (PIXEL_W+1)'(-diff) : (PIXEL_W+1)'(diff);
      w_sat      = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
      prod       = 27'(diff) * 27'($signed({1'b0, w_sat}));
      num        = $signed({{4{mean_ff[PIXEL_W-1]}}, mean_ff, 8'h00}) + 28'(prod)
                   + 28'sd128;
      mean_valid = (mean_ff > cfg.window_low) && (mean_ff < cfg.window_high);
      smooth_pos = !smooth_ff[PIXEL_W-1] && (smooth_ff != '0);
      smooth_in  = smooth_ff;
      if (cmd.smooth) begin
         if (smooth_pos && mean_valid) begin
            if (abs_diff < (PIXEL_W+1)'(cfg.jump_limit)) begin
               smooth_in = num[23:8];
            end else begin
               smooth_in = mean_ff;
            end
         end else if (smooth_ff[PIXEL_W-1] && mean_valid) begin
            smooth_in = mean_ff;
         end else begin
            smooth_in = SENTINEL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         present_ff <= 1'b0;
         stable_ff  <= 1'b0;
         timer_ff   <= '0;
         smooth_ff  <= '0;
      end else begin
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         stable_ff  <= stable_in;
         timer_ff   <= timer_in;
         smooth_ff  <= smooth_in;
      end
   end

   // Capture registers and result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cap_count_ff <= count_ff;
         sum_neg_ff   <= sum_ff[SW-1];
      end
      if (cmd.mean) begin
         mean_ff <= mean_in;
      end
      if (cmd.push) begin
         out_count_ff   <= cap_ext[COUNT_W-1:0];
         out_mean_ff    <= mean_ff;
         out_smooth_ff  <= smooth_ff;
         out_present_ff <= present_ff;
         out_stable_ff  <= stable_ff;
      end
   end

   assign in_range_count = out_count_ff;
   assign frame_mean     = out_mean_ff;
   assign smoothed_mean  = out_smooth_ff;
   assign present_now    = out_present_ff;
   assign present_stable = out_stable_ff;

endmodule

[rtl/core/tfmt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal frame mean tracker controller
// Sequences pixel intake, frame capture, divide, smoothing and result output.
// ----------------------------------------------------------------------------
`include "thermal_frame_mean_tracker_core_defines.svh"

module tfmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_frame_end,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tfmt_pkg::cmd_type  cmd,
   input  tfmt_pkg::stat_type st
);
   import tfmt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_frame_end) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = st.count_zero ? ST_MEAN : ST_DIV;
         end
         ST_DIV: begin
            if (st.div_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean = 1'b1;
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TFMT_ASSERT(a_push_when_free, cmd.push |-> (!rsp_valid_ff || rsp_ready), "result word overwritten")
   `TFMT_ASSERT(a_frame_end_capture, (req_valid && req_ready && req_frame_end) |=> (state_ff == ST_LOAD), "frame end not captured")
   `TFMT_ASSERT(a_div_done_in_div, st.div_done |-> (state_ff == ST_DIV), "divider finished outside divide state")

endmodule
